>>> rtl/sfs_pkg.sv
// Shared definitions for the stepper feed sequencer: field widths,
// command codes, configuration register indexes and the full-step coil table.
// No dependencies.
package sfs_pkg;

    localparam int AMOUNT_W = 10;
    localparam int STEPS_W  = 12;
    localparam int PERIOD_W = 16;
    localparam int PHASE_W  = 2;
    localparam int COILS_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    // command codes carried in tuser
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_AMOUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_BACK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_FORWARD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD    = 2'd3;

    // reset values of the configuration registers
    localparam logic [AMOUNT_W-1:0] RST_DEFAULT_AMOUNT = 10'd1;
    localparam logic [STEPS_W-1:0]  RST_STEPS_BACK     = 12'd0;
    localparam logic [STEPS_W-1:0]  RST_STEPS_FORWARD  = 12'd2048;
    localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD    = 16'd1000;

    typedef logic [COILS_W-1:0] t_coils;

    function automatic t_coils full_step(input logic [PHASE_W-1:0] ph);
        t_coils c;
        case (ph)
            2'd0:    c = 4'b1010;
            2'd1:    c = 4'b0110;
            2'd2:    c = 4'b0101;
            2'd3:    c = 4'b1001;
            default: c = 4'b0000;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/stepper_feed_sequencer.sv
// A coil word is registered in the output register, or in the skid entry while the sink
// stalls, before it shows on the master side. Throughput: one command or tick word per
// cycle while the skid entry is empty; every word is handled in the single cycle it is
// accepted; output register and one-entry skid keep intake up for one word of sink stall.
// Reset (synchronous, active low): idle, phase 0, output empty, registers at defaults.
// Top level: step sequencer state, config registers and output buffering.
// Depends on sfs_pkg.
module stepper_feed_sequencer
    import sfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // command / tick words
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [9:0] amount, [15:10] zero
    input  logic                  s_axis_tuser,  // [0] opcode
    // coil words
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [3:0] coils, [7:4] zero
    output logic                  m_axis_tlast   // done_res
);

    // configuration
    logic [AMOUNT_W-1:0] r_default_amount;
    logic [STEPS_W-1:0]  r_steps_back;
    logic [STEPS_W-1:0]  r_steps_forward;
    logic [PERIOD_W-1:0] r_step_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_amount <= RST_DEFAULT_AMOUNT;
            r_steps_back     <= RST_STEPS_BACK;
            r_steps_forward  <= RST_STEPS_FORWARD;
            r_step_period    <= RST_STEP_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEFAULT_AMOUNT: r_default_amount <= i_cfg_data[AMOUNT_W-1:0];
                REG_STEPS_BACK:     r_steps_back     <= i_cfg_data[STEPS_W-1:0];
                REG_STEPS_FORWARD:  r_steps_forward  <= i_cfg_data[STEPS_W-1:0];
                REG_STEP_PERIOD:    r_step_period    <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    logic [PHASE_W-1:0]  r_phase,   n_phase;
    logic                r_busy,    n_busy;
    logic                r_fwd,     n_fwd;
    logic [AMOUNT_W-1:0] r_revs,    n_revs;
    logic [STEPS_W-1:0]  r_steps,   n_steps;
    logic [PERIOD_W-1:0] r_wait,    n_wait;

    // output register and skid entry
    logic                r_out_valid;
    t_coils              r_out_coils;
    logic                r_out_done;
    logic                r_skid_valid;
    t_coils              r_skid_coils;
    logic                r_skid_done;

    logic                accept;
    logic                pop;
    logic                res_valid;
    t_coils              res_coils;
    logic                res_done;
    logic [AMOUNT_W-1:0] amount;

    assign s_axis_tready = !r_skid_valid;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop    = r_out_valid && m_axis_tready;
    assign amount = s_axis_tdata[AMOUNT_W-1:0];

    always_comb begin
        logic fin;
        n_phase   = r_phase;
        n_busy    = r_busy;
        n_fwd     = r_fwd;
        n_revs    = r_revs;
        n_steps   = r_steps;
        n_wait    = r_wait;
        res_valid = 1'b0;
        res_coils = '0;
        res_done  = 1'b0;
        fin       = 1'b0;
        if (accept) begin
            if (s_axis_tuser == OP_START) begin
                if (!r_busy) begin
                    n_busy  = 1'b1;
                    n_revs  = (amount == '0) ? r_default_amount : amount;
                    n_fwd   = 1'b1;
                    n_steps = '0;
                    n_wait  = '0;
                end
            end else if (r_busy) begin
                if (r_wait > PERIOD_W'(1)) begin
                    n_wait = r_wait - PERIOD_W'(1);
                end else begin
                    // step point: find a segment with a step left
                    res_valid = 1'b1;
                    if (r_steps_back == '0 && r_steps_forward == '0) begin
                        fin = 1'b1;
                    end else if (r_steps == '0) begin
                        if (!r_fwd) begin
                            if (r_steps_forward != '0) begin
                                n_fwd   = 1'b1;
                                n_steps = r_steps_forward;
                            end else if (r_revs == '0) begin
                                fin = 1'b1;
                            end else begin
                                // empty forward segment, straight into next revolution
                                n_revs  = r_revs - AMOUNT_W'(1);
                                n_fwd   = 1'b0;
                                n_steps = r_steps_back;
                            end
                        end else if (r_revs == '0) begin
                            fin = 1'b1;
                        end else begin
                            n_revs = r_revs - AMOUNT_W'(1);
                            if (r_steps_back == '0) begin
                                n_fwd   = 1'b1;
                                n_steps = r_steps_forward;
                            end else begin
                                n_fwd   = 1'b0;
                                n_steps = r_steps_back;
                            end
                        end
                    end
                    if (fin) begin
                        res_done = 1'b1;
                        n_busy   = 1'b0;
                        n_fwd    = 1'b0;
                        n_revs   = '0;
                        n_steps  = '0;
                        n_wait   = '0;
                    end else begin
                        res_coils = full_step(r_phase);
                        n_phase   = n_fwd ? r_phase + PHASE_W'(1) : r_phase - PHASE_W'(1);
                        n_steps   = n_steps - STEPS_W'(1);
                        n_wait    = r_step_period;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_busy  <= 1'b0;
            r_fwd   <= 1'b0;
            r_revs  <= '0;
            r_steps <= '0;
            r_wait  <= '0;
        end else begin
            r_phase <= n_phase;
            r_busy  <= n_busy;
            r_fwd   <= n_fwd;
            r_revs  <= n_revs;
            r_steps <= n_steps;
            r_wait  <= n_wait;
        end
    end

    // output buffering: new word goes to the skid entry only when the
    // output register is held by a stalled sink
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out_coils <= r_skid_coils;
                r_out_done  <= r_skid_done;
            end
        end else if (res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_coils <= res_coils;
                r_out_done  <= res_done;
            end else begin
                r_skid_coils <= res_coils;
                r_skid_done  <= res_done;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_TDATA_W - COILS_W)'(0), r_out_coils};
    assign m_axis_tlast  = r_out_done;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output word");

    a_done_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("done word with coils driven");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_steps == '0 && r_wait == '0 && r_revs == '0 && !r_fwd))
        else $error("idle sequencer with run state left");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid filled while sink was free");

    a_busy_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> (r_out_valid || r_skid_valid))
        else $error("run ended without done word");
`endif

endmodule
